@@ rtl/fenp_pkg.sv @@
`timescale 1ns / 1ps

package fenp_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_SQUARE = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Text fields of one FEN line
  typedef enum logic [2:0] {
    PH_PLACE   = 3'd0,
    PH_SIDE    = 3'd1,
    PH_CASTLE  = 3'd2,
    PH_EP_FILE = 3'd3,
    PH_EP_RANK = 3'd4,
    PH_HALF    = 3'd5,
    PH_FULL    = 3'd6,
    PH_TRAIL   = 3'd7
  } phase_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ADD  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  // Shared arithmetic unit operations
  typedef enum logic {
    ALU_X5     = 1'b0,  // (a << 2) + b
    ALU_X2_ADD = 1'b1   // (a << 1) + b, saturated
  } alu_op_e;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_K  = 8'h4B;
  localparam logic [7:0] CH_UP_Q  = 8'h51;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_H  = 8'h68;
  localparam logic [7:0] CH_LO_K  = 8'h6B;
  localparam logic [7:0] CH_LO_Q  = 8'h71;
  localparam logic [7:0] CH_LO_W  = 8'h77;

  // Board geometry
  localparam logic [3:0] FILES_PER_RANK = 4'd8;
  localparam logic [2:0] TOP_RANK       = 3'd7;

  // Castle right bits
  localparam logic [3:0] CASTLE_WK = 4'b0001;
  localparam logic [3:0] CASTLE_WQ = 4'b0010;
  localparam logic [3:0] CASTLE_BK = 4'b0100;
  localparam logic [3:0] CASTLE_BQ = 4'b1000;

  localparam logic [3:0] EP_VALID = 4'b1000;

  // Piece letter to square code, 0 when not a piece letter
  function automatic logic [3:0] piece_of(input logic [7:0] c);
    logic [3:0] p;
    begin
      case (c)
        8'h51:   p = 4'd1;   // Q
        8'h52:   p = 4'd2;   // R
        8'h42:   p = 4'd3;   // B
        8'h50:   p = 4'd4;   // P
        8'h4E:   p = 4'd5;   // N
        8'h4B:   p = 4'd6;   // K
        8'h71:   p = 4'd9;   // q
        8'h72:   p = 4'd10;  // r
        8'h62:   p = 4'd11;  // b
        8'h70:   p = 4'd12;  // p
        8'h6E:   p = 4'd13;  // n
        8'h6B:   p = 4'd14;  // k
        default: p = 4'd0;
      endcase
      return p;
    end
  endfunction

endpackage

@@ rtl/fen_position_parser.sv @@
`timescale 1ns / 1ps

// Channel | direction | handshake              | word
// in      | input     | in_valid_i / in_stall_o   | char_code_i
// out     | output    | out_valid_o / out_stall_i | kind_o .. last_o
//
// Bytes are accepted while the sequencer is idle; the block then waits until the result
// register drains. A counter digit makes two passes of the shared shift-add unit (5x in
// ST_MUL, then 2x plus digit in ST_ADD). A placement digit n emits n square
// words, one per cycle that the output is not stalled.
// Reset (rst_ni low, asynchronous) puts the parser at rank eight, file a.
// Output stall holds the result register and blocks further input.
module fen_position_parser import fenp_pkg::*; #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  square_row_o,
  output logic [2:0]  square_col_o,
  output logic [3:0]  piece_code_o,
  output logic        white_next_o,
  output logic [3:0]  castle_rights_o,
  output logic [3:0]  en_passant_o,
  output logic [15:0] halfmove_cnt_o,
  output logic [15:0] fullmove_cnt_o,
  output logic        last_o
);

  localparam int unsigned AccBits = COUNTER_BITS + 4;

  // parser state
  state_e                  state_q, state_d;
  phase_e                  phase_q, phase_d;
  logic [2:0]              rank_q, rank_d;
  logic [3:0]              file_q, file_d;
  logic                    side_q, side_d;
  logic [3:0]              castle_q, castle_d;
  logic [3:0]              ep_q, ep_d;
  logic [COUNTER_BITS-1:0] half_q, half_d;
  logic [COUNTER_BITS-1:0] full_q, full_d;
  logic                    skip_q, skip_d;
  logic [3:0]              emit_cnt_q, emit_cnt_d;
  logic [3:0]              digit_q, digit_d;
  logic                    sel_full_q, sel_full_d;
  logic [AccBits-1:0]      acc_q, acc_d;

  // result register
  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [2:0]  row_q, row_d;
  logic [2:0]  col_q, col_d;
  logic [3:0]  piece_q, piece_d;
  logic        wtm_q, wtm_d;
  logic [3:0]  cr_q, cr_d;
  logic [3:0]  epo_q, epo_d;
  logic [15:0] hmc_q, hmc_d;
  logic [15:0] fmn_q, fmn_d;
  logic        last_q, last_d;

  logic out_free, in_accept;

  // shared arithmetic unit
  alu_op_e                 alu_op;
  logic [AccBits-1:0]      alu_a, alu_b, alu_sum;
  logic [COUNTER_BITS-1:0] alu_sat, cur_cnt;

  assign cur_cnt = sel_full_q ? full_q : half_q;
  assign alu_op  = (state_q == ST_MUL) ? ALU_X5 : ALU_X2_ADD;
  assign alu_a   = (state_q == ST_MUL) ? AccBits'(cur_cnt) : acc_q;
  assign alu_b   = (state_q == ST_MUL) ? AccBits'(cur_cnt) : AccBits'(digit_q);

  fenp_alu #(.CntBits(COUNTER_BITS)) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum),
    .sat_o (alu_sat)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  // byte classification and sequencer
  always_comb begin
    logic       is_eol, is_ws, is_cdig, is_pdig;
    logic [3:0] pc, dval;
    logic [4:0] file_end;
    logic       emit, fail;
    kind_e      e_kind;
    logic [2:0] e_row, e_col;
    logic [3:0] e_piece;
    logic       e_last;

    is_eol   = (char_code_i == CH_LF) || (char_code_i == CH_CR) || (char_code_i == CH_NUL);
    is_ws    = (char_code_i == CH_SPACE) || (char_code_i == CH_TAB);
    is_cdig  = (char_code_i >= CH_0) && (char_code_i <= CH_9);
    is_pdig  = (char_code_i >= CH_1) && (char_code_i <= CH_8);
    pc       = piece_of(char_code_i);
    dval     = 4'(char_code_i - CH_0);
    file_end = {1'b0, file_q} + {1'b0, dval};

    state_d    = state_q;
    phase_d    = phase_q;
    rank_d     = rank_q;
    file_d     = file_q;
    side_d     = side_q;
    castle_d   = castle_q;
    ep_d       = ep_q;
    half_d     = half_q;
    full_d     = full_q;
    skip_d     = skip_q;
    emit_cnt_d = emit_cnt_q;
    digit_d    = digit_q;
    sel_full_d = sel_full_q;
    acc_d      = acc_q;

    emit    = 1'b0;
    fail    = 1'b0;
    e_kind  = KIND_SQUARE;
    e_row   = '0;
    e_col   = '0;
    e_piece = '0;
    e_last  = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (is_eol) begin
            // line end: record, error or nothing, then start over
            if (!skip_q) begin
              if ((phase_q == PH_TRAIL) || ((phase_q == PH_FULL) && (file_q != '0))) begin
                emit   = 1'b1;
                e_kind = KIND_RECORD;
              end else if (!((phase_q == PH_PLACE) && (rank_q == TOP_RANK) &&
                             (file_q == '0))) begin
                emit   = 1'b1;
                e_kind = KIND_ERROR;
              end
            end
            phase_d  = PH_PLACE;
            rank_d   = TOP_RANK;
            file_d   = '0;
            side_d   = 1'b0;
            castle_d = '0;
            ep_d     = '0;
            half_d   = '0;
            full_d   = '0;
            skip_d   = 1'b0;
          end else if (!skip_q) begin
            case (phase_q)
              PH_PLACE: begin
                if (is_ws) begin
                  phase_d = PH_SIDE;
                  file_d  = '0;
                end else if (pc != '0) begin
                  if (file_q >= FILES_PER_RANK) begin
                    fail = 1'b1;
                  end else begin
                    emit    = 1'b1;
                    e_row   = rank_q;
                    e_col   = file_q[2:0];
                    e_piece = pc;
                    file_d  = file_q + 4'd1;
                  end
                end else if (is_pdig) begin
                  if (file_end > {1'b0, FILES_PER_RANK}) begin
                    fail = 1'b1;
                  end else begin
                    emit_cnt_d = dval;
                    state_d    = ST_EMIT;
                  end
                end else if (char_code_i == CH_SLASH) begin
                  if (rank_q == '0) begin
                    fail = 1'b1;
                  end else begin
                    rank_d = rank_q - 3'd1;
                    file_d = '0;
                  end
                end else begin
                  fail = 1'b1;
                end
              end
              PH_SIDE: begin
                if (is_ws) begin
                  if (file_q != '0) begin
                    phase_d = PH_CASTLE;
                    file_d  = '0;
                  end
                end else if ((file_q == '0) &&
                             ((char_code_i == CH_LO_W) || (char_code_i == CH_LO_B))) begin
                  side_d = (char_code_i == CH_LO_W);
                  file_d = 4'd1;
                end else begin
                  fail = 1'b1;
                end
              end
              PH_CASTLE: begin
                if (is_ws) begin
                  if (file_q != '0) begin
                    phase_d = PH_EP_FILE;
                    file_d  = '0;
                  end
                end else if (char_code_i == CH_UP_K) begin
                  castle_d = castle_q | CASTLE_WK;
                  file_d   = 4'd1;
                end else if (char_code_i == CH_UP_Q) begin
                  castle_d = castle_q | CASTLE_WQ;
                  file_d   = 4'd1;
                end else if (char_code_i == CH_LO_K) begin
                  castle_d = castle_q | CASTLE_BK;
                  file_d   = 4'd1;
                end else if (char_code_i == CH_LO_Q) begin
                  castle_d = castle_q | CASTLE_BQ;
                  file_d   = 4'd1;
                end else if (char_code_i == CH_DASH) begin
                  castle_d = '0;
                  file_d   = 4'd1;
                end else begin
                  fail = 1'b1;
                end
              end
              PH_EP_FILE: begin
                if (is_ws) begin
                  // leading separators skipped
                end else if (char_code_i == CH_DASH) begin
                  ep_d    = '0;
                  phase_d = PH_HALF;
                  file_d  = '0;
                end else if ((char_code_i >= CH_LO_A) && (char_code_i <= CH_LO_H)) begin
                  ep_d    = EP_VALID | {1'b0, 3'(char_code_i - CH_LO_A)};
                  phase_d = PH_EP_RANK;
                end else begin
                  fail = 1'b1;
                end
              end
              PH_EP_RANK: begin
                // rank character is skipped whatever it is
                phase_d = PH_HALF;
                file_d  = '0;
              end
              PH_HALF, PH_FULL: begin
                if (is_ws) begin
                  if (file_q != '0) begin
                    phase_d = (phase_q == PH_HALF) ? PH_FULL : PH_TRAIL;
                    file_d  = '0;
                  end
                end else if (is_cdig) begin
                  digit_d    = dval;
                  sel_full_d = (phase_q == PH_FULL);
                  file_d     = 4'd1;
                  state_d    = ST_MUL;
                end else begin
                  fail = 1'b1;
                end
              end
              default: begin
                // trailing text ignored
              end
            endcase
            // a bad byte's error word leaves last low
            if (fail) begin
              emit   = 1'b1;
              e_kind = KIND_ERROR;
              e_last = 1'b0;
              skip_d = 1'b1;
            end
          end
        end
      end
      ST_MUL: begin
        acc_d   = alu_sum;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (sel_full_q) begin
          full_d = alu_sat;
        end else begin
          half_d = alu_sat;
        end
        state_d = ST_IDLE;
      end
      ST_EMIT: begin
        // one empty square per free output cycle
        if (out_free) begin
          emit       = 1'b1;
          e_row      = rank_q;
          e_col      = file_q[2:0];
          e_last     = (emit_cnt_q == 4'd1);
          file_d     = file_q + 4'd1;
          emit_cnt_d = emit_cnt_q - 4'd1;
          if (emit_cnt_q == 4'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // result register load
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    row_d       = row_q;
    col_d       = col_q;
    piece_d     = piece_q;
    wtm_d       = wtm_q;
    cr_d        = cr_q;
    epo_d       = epo_q;
    hmc_d       = hmc_q;
    fmn_d       = fmn_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      kind_d      = e_kind;
      row_d       = e_row;
      col_d       = e_col;
      piece_d     = e_piece;
      last_d      = e_last;
      if (e_kind == KIND_RECORD) begin
        wtm_d = side_q;
        cr_d  = castle_q;
        epo_d = ep_q;
        hmc_d = 16'(half_q);
        fmn_d = 16'(full_q);
      end else begin
        wtm_d = 1'b0;
        cr_d  = '0;
        epo_d = '0;
        hmc_d = '0;
        fmn_d = '0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_PLACE;
      rank_q      <= TOP_RANK;
      file_q      <= '0;
      side_q      <= 1'b0;
      castle_q    <= '0;
      ep_q        <= '0;
      half_q      <= '0;
      full_q      <= '0;
      skip_q      <= 1'b0;
      emit_cnt_q  <= '0;
      sel_full_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      rank_q      <= rank_d;
      file_q      <= file_d;
      side_q      <= side_d;
      castle_q    <= castle_d;
      ep_q        <= ep_d;
      half_q      <= half_d;
      full_q      <= full_d;
      skip_q      <= skip_d;
      emit_cnt_q  <= emit_cnt_d;
      sel_full_q  <= sel_full_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    acc_q   <= acc_d;
    kind_q  <= kind_d;
    row_q   <= row_d;
    col_q   <= col_d;
    piece_q <= piece_d;
    wtm_q   <= wtm_d;
    cr_q    <= cr_d;
    epo_q   <= epo_d;
    hmc_q   <= hmc_d;
    fmn_q   <= fmn_d;
    last_q  <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign square_row_o    = row_q;
  assign square_col_o    = col_q;
  assign piece_code_o    = piece_q;
  assign white_next_o    = wtm_q;
  assign castle_rights_o = cr_q;
  assign en_passant_o    = epo_q;
  assign halfmove_cnt_o  = hmc_q;
  assign fullmove_cnt_o  = fmn_q;
  assign last_o          = last_q;

  // checks
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_mul_then_add : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |=> (state_q == ST_ADD))
    else $error("multiply pass not followed by add pass");

  a_file_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PLACE) |-> (file_q <= FILES_PER_RANK))
    else $error("file position past file h");

  a_emit_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (({1'b0, file_q} + {1'b0, emit_cnt_q}) <= 5'd8) &&
                             (emit_cnt_q != '0))
    else $error("empty square run does not fit the rank");

endmodule

@@ rtl/fenp_alu.sv @@
`timescale 1ns / 1ps

// Shared shift-add unit for the decimal counters: x*10+d in two passes.
module fenp_alu import fenp_pkg::*; #(
  parameter int unsigned CntBits = 16,
  localparam int unsigned AccBits = CntBits + 4
) (
  input  alu_op_e              op_i,
  input  logic [AccBits-1:0]   a_i,
  input  logic [AccBits-1:0]   b_i,
  output logic [AccBits-1:0]   sum_o,
  output logic [CntBits-1:0]   sat_o
);

  localparam logic [AccBits-1:0] MaxVal = {{4{1'b0}}, {CntBits{1'b1}}};

  logic [AccBits-1:0] shifted;

  // shift then add
  assign shifted = (op_i == ALU_X5) ? (a_i << 2) : (a_i << 1);
  assign sum_o   = shifted + b_i;

  // clamp to the counter range
  assign sat_o = (sum_o > MaxVal) ? {CntBits{1'b1}} : sum_o[CntBits-1:0];

endmodule

@@ verif/tb_fen_position_parser.sv @@
`timescale 1ns / 1ps

module tb_fen_position_parser;
  import fenp_pkg::*;

  localparam int COUNT_BITS = 16;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
  localparam int TEXT_TARGET = 360;
  localparam int HOLD_AT = 300;   // cycle where the long output hold-off starts
  localparam int HOLD_LEN = 200;
  localparam int DRAIN_CYCLES = 20;

  // Piece values as they appear on the square word
  localparam logic [3:0] CODE_QUEEN  = 4'd1;
  localparam logic [3:0] CODE_ROOK   = 4'd2;
  localparam logic [3:0] CODE_BISHOP = 4'd3;
  localparam logic [3:0] CODE_PAWN   = 4'd4;
  localparam logic [3:0] CODE_KNIGHT = 4'd5;
  localparam logic [3:0] CODE_KING   = 4'd6;
  localparam logic [3:0] CODE_BLACK  = 4'd8;

  typedef struct {
    kind_e       kind;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [3:0]  piece;
    logic        wtm;
    logic [3:0]  castle;
    logic [3:0]  ep;
    logic [15:0] half;
    logic [15:0] full;
    logic        is_last;
  } fen_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  char_code_i = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [2:0]  square_row_o;
  logic [2:0]  square_col_o;
  logic [3:0]  piece_code_o;
  logic        white_next_o;
  logic [3:0]  castle_rights_o;
  logic [3:0]  en_passant_o;
  logic [15:0] halfmove_cnt_o;
  logic [15:0] fullmove_cnt_o;
  logic        last_o;

  fen_position_parser #(
    .COUNTER_BITS(COUNT_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_code_i     (char_code_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .square_row_o    (square_row_o),
    .square_col_o    (square_col_o),
    .piece_code_o    (piece_code_o),
    .white_next_o    (white_next_o),
    .castle_rights_o (castle_rights_o),
    .en_passant_o    (en_passant_o),
    .halfmove_cnt_o  (halfmove_cnt_o),
    .fullmove_cnt_o  (fullmove_cnt_o),
    .last_o          (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Text bytes waiting to be sent, and words the parser owes us
  logic [7:0]  text_q[$];
  logic [7:0]  line_buf[$];
  fen_word_t   expected_words[$];
  string       piece_letters = "QRBPNKqrbpnk";
  string       castle_letters = "KQkq-";

  int unsigned total_bytes = 0;
  int unsigned bytes_taken = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches = 0;
  int unsigned lines_done = 0;
  int unsigned squares_due = 0;
  int unsigned records_due = 0;
  int unsigned errors_due = 0;

  // Parser state as the text so far leaves it
  phase_e      cur_phase;
  logic [2:0]  cur_rank;
  logic [3:0]  cur_file;   // past placement: "field has content"
  logic        side_white;
  logic [3:0]  castles;
  logic [3:0]  ep_bits;
  int unsigned half_cnt;
  int unsigned full_cnt;
  logic        skipping;

  function automatic void restart_line();
    cur_phase = PH_PLACE;
    cur_rank = TOP_RANK;
    cur_file = '0;
    side_white = 1'b0;
    castles = '0;
    ep_bits = '0;
    half_cnt = 0;
    full_cnt = 0;
    skipping = 1'b0;
  endfunction

  // Case fold: only 'X' and 'x' both land on 'X'; bit 5 marks lower case
  function automatic logic [3:0] letter_piece(logic [7:0] c);
    logic [3:0] code;
    case (c & 8'hDF)
      "Q":     code = CODE_QUEEN;
      "R":     code = CODE_ROOK;
      "B":     code = CODE_BISHOP;
      "P":     code = CODE_PAWN;
      "N":     code = CODE_KNIGHT;
      "K":     code = CODE_KING;
      default: code = 4'd0;
    endcase
    if (code != 4'd0 && c[5]) code = code | CODE_BLACK;
    return code;
  endfunction

  function automatic int unsigned grow_count(int unsigned v, logic [7:0] c);
    longint unsigned t;
    t = longint'(v) * 10 + longint'(c - CH_0);
    return (t > COUNT_MAX) ? int'(COUNT_MAX) : int'(t);
  endfunction

  function automatic void emit(kind_e k, logic [2:0] row, logic [2:0] col,
                               logic [3:0] piece);
    fen_word_t w;
    w.kind = k;
    w.row = row;
    w.col = col;
    w.piece = piece;
    w.is_last = 1'b0;
    if (k == KIND_RECORD) begin
      w.wtm = side_white;
      w.castle = castles;
      w.ep = ep_bits;
      w.half = half_cnt[15:0];
      w.full = full_cnt[15:0];
      records_due++;
    end else begin
      w.wtm = 1'b0;
      w.castle = '0;
      w.ep = '0;
      w.half = '0;
      w.full = '0;
      if (k == KIND_SQUARE) squares_due++;
      else errors_due++;
    end
    expected_words.push_back(w);
  endfunction

  // Advance the parser state by one byte and queue the words it causes
  function automatic void parse_byte(logic [7:0] c);
    bit          is_sep;
    bit          is_digit;
    bit          bad;
    int unsigned first;
    int unsigned cnt;
    logic [3:0]  pc;
    is_sep = (c == CH_SPACE || c == CH_TAB);
    is_digit = (c >= CH_0 && c <= CH_9);
    bad = 1'b0;
    first = expected_words.size();
    pc = letter_piece(c);
    if (c == CH_LF || c == CH_CR || c == CH_NUL) begin
      lines_done++;
      if (!skipping) begin
        if (cur_phase == PH_TRAIL || (cur_phase == PH_FULL && cur_file != 0))
          emit(KIND_RECORD, '0, '0, '0);
        else if (!(cur_phase == PH_PLACE && cur_rank == TOP_RANK && cur_file == 0))
          emit(KIND_ERROR, '0, '0, '0);   // line cut short
      end
      restart_line();
    end else if (!skipping) begin
      case (cur_phase)
        PH_PLACE: begin
          if (is_sep) begin
            cur_phase = PH_SIDE;
            cur_file = '0;
          end else if (pc != 0) begin
            if (cur_file >= FILES_PER_RANK) begin
              bad = 1'b1;
            end else begin
              emit(KIND_SQUARE, cur_rank, cur_file[2:0], pc);
              cur_file++;
            end
          end else if (c >= CH_1 && c <= CH_8) begin
            cnt = c - CH_0;
            if (cur_file + cnt > FILES_PER_RANK) begin
              bad = 1'b1;   // overflowing run emits no squares
            end else begin
              repeat (cnt) begin
                emit(KIND_SQUARE, cur_rank, cur_file[2:0], 4'd0);
                cur_file++;
              end
            end
          end else if (c == CH_SLASH) begin
            if (cur_rank == 0) begin
              bad = 1'b1;
            end else begin
              cur_rank--;
              cur_file = '0;
            end
          end else begin
            bad = 1'b1;
          end
        end
        PH_SIDE: begin
          if (is_sep) begin
            if (cur_file != 0) begin
              cur_phase = PH_CASTLE;
              cur_file = '0;
            end
          end else if (cur_file == 0 && (c == CH_LO_W || c == CH_LO_B)) begin
            side_white = (c == CH_LO_W);
            cur_file = 4'd1;
          end else begin
            bad = 1'b1;   // includes a second side letter
          end
        end
        PH_CASTLE: begin
          if (is_sep) begin
            if (cur_file != 0) begin
              cur_phase = PH_EP_FILE;
              cur_file = '0;
            end
          end else if (c == CH_UP_K) begin
            castles |= CASTLE_WK;
            cur_file = 4'd1;
          end else if (c == CH_UP_Q) begin
            castles |= CASTLE_WQ;
            cur_file = 4'd1;
          end else if (c == CH_LO_K) begin
            castles |= CASTLE_BK;
            cur_file = 4'd1;
          end else if (c == CH_LO_Q) begin
            castles |= CASTLE_BQ;
            cur_file = 4'd1;
          end else if (c == CH_DASH) begin
            castles = '0;
            cur_file = 4'd1;
          end else begin
            bad = 1'b1;
          end
        end
        PH_EP_FILE: begin
          if (is_sep) begin
            // leading blanks skipped
          end else if (c == CH_DASH) begin
            ep_bits = '0;
            cur_phase = PH_HALF;
            cur_file = '0;
          end else if (c >= CH_LO_A && c <= CH_LO_H) begin
            ep_bits = EP_VALID | 4'(c - CH_LO_A);
            cur_phase = PH_EP_RANK;
          end else begin
            bad = 1'b1;
          end
        end
        PH_EP_RANK: begin
          // any byte stands for the rank
          cur_phase = PH_HALF;
          cur_file = '0;
        end
        PH_HALF, PH_FULL: begin
          if (is_sep) begin
            if (cur_file != 0) begin
              cur_phase = (cur_phase == PH_HALF) ? PH_FULL : PH_TRAIL;
              cur_file = '0;
            end
          end else if (is_digit) begin
            if (cur_phase == PH_HALF) half_cnt = grow_count(half_cnt, c);
            else full_cnt = grow_count(full_cnt, c);
            cur_file = 4'd1;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          // trailing text ignored
        end
      endcase
    end
    // A bad byte gives one error word with last low, then the line is dropped
    if (bad) begin
      skipping = 1'b1;
      emit(KIND_ERROR, '0, '0, '0);
    end else if (expected_words.size() > first) begin
      expected_words[$].is_last = 1'b1;
    end
  endfunction

  // Text generation
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void add_sep();
    repeat ((($urandom % 4) == 0) ? 2 : 1)
      line_buf.push_back((($urandom % 3) == 0) ? CH_TAB : CH_SPACE);
  endfunction

  function automatic void add_number();
    int unsigned ndig;
    ndig = (($urandom % 8) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 3);
    repeat (ndig) line_buf.push_back(CH_0 + 8'($urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == CH_LF || b == CH_CR) b = CH_SPACE;
    return b;
  endfunction

  // One FEN line in line_buf; overfill pushes the board past its edges
  function automatic void build_line(bit overfill);
    int unsigned nranks;
    int unsigned files;
    int unsigned d;
    int unsigned n;
    line_buf.delete();
    nranks = (($urandom % 4) == 0) ? $urandom_range(1, 8) : 8;
    if (overfill && ($urandom % 2)) nranks = 9;   // slash below rank one
    for (int r = 0; r < nranks; r++) begin
      files = 0;
      while (files < 8 && ($urandom % 24) != 0) begin
        if (($urandom % 3) == 0) begin
          d = $urandom_range(1, 8 - files);
          line_buf.push_back(CH_0 + 8'(d));
          files += d;
        end else begin
          line_buf.push_back(piece_letters[$urandom_range(0, 11)]);
          files++;
        end
      end
      if (overfill && r == nranks - 1)
        line_buf.push_back(($urandom % 2) ? piece_letters[$urandom_range(0, 11)]
                                          : CH_0 + 8'($urandom_range(1, 8)));
      if (r < nranks - 1) line_buf.push_back(CH_SLASH);
    end
    add_sep();
    line_buf.push_back(($urandom % 2) ? CH_LO_W : CH_LO_B);
    add_sep();
    n = $urandom_range(0, 4);
    if (n == 0) line_buf.push_back(CH_DASH);
    repeat (n) line_buf.push_back(castle_letters[$urandom_range(0, 4)]);
    add_sep();
    if (($urandom % 3) == 0) begin
      line_buf.push_back(CH_DASH);
    end else begin
      line_buf.push_back(CH_LO_A + 8'($urandom_range(0, 7)));
      line_buf.push_back(($urandom % 4) ? (($urandom % 2) ? "3" : "6") : plain_byte());
    end
    add_sep();
    add_number();
    add_sep();
    add_number();
    if (($urandom % 3) == 0) begin
      add_sep();
      repeat ($urandom_range(1, 5)) line_buf.push_back(plain_byte());
    end
    case ($urandom % 4)
      0: line_buf.push_back(CH_LF);
      1: begin
        line_buf.push_back(CH_CR);
        line_buf.push_back(CH_LF);
      end
      2: line_buf.push_back(CH_CR);
      default: line_buf.push_back(CH_NUL);
    endcase
  endfunction

  // Sender: bursts of random length with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      char_code_i <= 8'h00;
      burst_left <= 1;
      gap_left <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (text_q.size() != 0) begin
        in_valid_i <= 1'b1;
        char_code_i <= text_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= (($urandom % 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern changes with bits 8:7 of the cycle counter, plus one long hold-off
  int unsigned stall_cycle = 0;
  int unsigned hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : stall_driver
    logic stall_next;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_cycle <= 0;
      hold_left <= 0;
    end else begin
      case (stall_cycle[8:7])
        2'd0:    stall_next = 1'b0;
        2'd1:    stall_next = (($urandom % 4) == 0);
        2'd2:    stall_next = (stall_cycle[1:0] == 2'd0);
        default: stall_next = (($urandom % 4) != 0);
      endcase
      if (stall_cycle == HOLD_AT) begin
        hold_left <= HOLD_LEN;
        stall_next = 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        stall_next = 1'b1;
      end
      out_stall_i <= stall_next;
      stall_cycle <= stall_cycle + 1;
    end
  end

  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: predict on each accepted byte, check each accepted word
  always @(posedge clk_i) begin : word_monitor
    fen_word_t w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        parse_byte(char_code_i);
        bytes_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("word with none pending: kind %0d", kind_o);
          mismatches++;
        end else begin
          w = expected_words.pop_front();
          words_checked++;
          compare_field("kind", w.kind, kind_o);
          compare_field("square_row", w.row, square_row_o);
          compare_field("square_col", w.col, square_col_o);
          compare_field("piece_code", w.piece, piece_code_o);
          compare_field("white_next", w.wtm, white_next_o);
          compare_field("castle_rights", w.castle, castle_rights_o);
          compare_field("en_passant", w.ep, en_passant_o);
          compare_field("halfmove_cnt", w.half, halfmove_cnt_o);
          compare_field("fullmove_cnt", w.full, fullmove_cnt_o);
          compare_field("last", w.is_last, last_o);
        end
      end
    end
  end

  initial begin
    restart_line();

    // Directed: empty lines, a full rank pair, overflow, saturation, trail
    text_q.push_back(CH_LF);
    text_q.push_back(CH_CR);
    text_q.push_back(CH_LF);
    add_text("k7/8");
    text_q.push_back(CH_NUL);
    add_text("8P");
    text_q.push_back(CH_LF);
    add_text("45");
    text_q.push_back(CH_CR);
    add_text("8 b K- h3 99999 7 x");
    text_q.push_back(CH_LF);

    // Random: mostly clean lines, some broken ones, some noise
    while (text_q.size() < TEXT_TARGET) begin
      case ($urandom % 10)
        0, 1, 2, 3, 4, 5: build_line(1'b0);
        6, 7: begin
          build_line($urandom % 2);
          if ($urandom % 2)
            line_buf = line_buf[0:$urandom_range(0, line_buf.size() - 2)];
          else
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
          line_buf.push_back(CH_LF);
        end
        default: begin
          line_buf.delete();
          repeat ($urandom_range(3, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
          line_buf.push_back(CH_LF);
        end
      endcase
      foreach (line_buf[i]) text_q.push_back(line_buf[i]);
    end
    total_bytes = text_q.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken < total_bytes) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d bytes in %0d lines, %0d words checked", bytes_taken, lines_done,
             words_checked);
    $display("run: %0d squares, %0d records, %0d errors predicted", squares_due,
             records_due, errors_due);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
rtl/fenp_pkg.sv
rtl/fenp_alu.sv
rtl/fen_position_parser.sv
verif/tb_fen_position_parser.sv
